// ----- design/xed_pkg.sv -----
package xed_pkg;

    // Default longest entity name held by the cell chain
    localparam int XED_MAX_NAME = 16;

    // Register indexes on the configuration port
    localparam logic CFG_DECODE_ENABLE = 1'b0;
    localparam logic CFG_TERMINATOR    = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_UNTERM   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Characters
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;

    // Reset values of the registers
    localparam logic       DECODE_ENABLE_RST = 1'b1;
    localparam logic [7:0] TERMINATOR_RST    = CH_LT;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_NAME,
        S_SEMI
    } state_t;

    // Control word broadcast to every cell of the name chain
    typedef struct packed {
        logic clear;
        logic append;
        logic shift;
    } cell_ctrl_t;

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic [1:0] status;
        logic       last_of_step;
    } result_t;

    // Character of a predefined entity, 0 if the name is not one of them.
    // len is the held name length when it is 2, 3 or 4, otherwise 0.
    function automatic logic [7:0] entity_char(
        input logic [7:0] c0,
        input logic [7:0] c1,
        input logic [7:0] c2,
        input logic [7:0] c3,
        input logic [2:0] len
    );
        logic [7:0] ch;
        ch = 8'h00;
        if (len == 3'd2 && c0 == "l" && c1 == "t")
            ch = CH_LT;
        else if (len == 3'd2 && c0 == "g" && c1 == "t")
            ch = CH_GT;
        else if (len == 3'd3 && c0 == "a" && c1 == "m" && c2 == "p")
            ch = CH_AMP;
        else if (len == 3'd4 && c0 == "a" && c1 == "p" && c2 == "o" && c3 == "s")
            ch = CH_APOS;
        else if (len == 3'd4 && c0 == "q" && c1 == "u" && c2 == "o" && c3 == "t")
            ch = CH_QUOT;
        return ch;
    endfunction

endpackage

// ----- design/xed_cell.sv -----
module xed_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  xed_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]        in_byte,
    input  logic              prev_full,
    input  logic              next_full,
    input  logic [7:0]        next_data,
    output logic [7:0]        data,
    output logic              full
);
    import xed_pkg::*;

    logic [7:0] data_reg, data_next;
    logic       full_reg, full_next;
    logic       take_byte;

    // A new byte lands in the first empty cell of the chain
    assign take_byte = ctrl.append && !full_reg && prev_full;

    // Next value: clear, shift toward the head, or capture
    always_comb
    begin
        full_next = full_reg;
        data_next = data_reg;
        if (ctrl.clear)
        begin
            full_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            full_next = next_full;
            data_next = next_data;
        end
        else if (take_byte)
        begin
            full_next = 1'b1;
            data_next = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign full = full_reg;

endmodule

// ----- design/xml_entity_decoder.sv -----
// Streaming decoder for XML text: takes one byte per word on the input channel and gives the
// decoded text on the output channel, replacing &lt; &gt; &amp; &apos; &quot; by their
// characters, passing any other reference on as its original text, ending a run on the
// configured terminator byte and flagging empty, unterminated and over-long references.
// Plain bytes and predefined references are decoded as each input byte is taken. A reference
// that is not predefined replays its text out of the name cell chain, one byte per cycle from
// the head cell while the output word is taken: after the '&' word the input is held until the
// name bytes and the closing ';' have gone out, and the replay waits while the output is not taken.
// Configuration is written through cfg_we / cfg_index / cfg_data while the block is idle.
module xml_entity_decoder #(
    parameter int MAX_NAME = xed_pkg::XED_MAX_NAME
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_end,
    output logic [1:0] status,
    output logic       last_of_step
);
    import xed_pkg::*;

    // Configuration registers
    logic       decode_enable_reg;
    logic [7:0] terminator_reg;

    // Control state
    state_t     state_reg, state_next;
    logic       in_ref_reg, in_ref_next;
    logic       eot_reg, eot_next;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg, res_next;

    // Name chain
    cell_ctrl_t        ctrl;
    logic [MAX_NAME:0] full_ext;
    logic [MAX_NAME-1:0] full_prev;
    logic [7:0]        cell_data [MAX_NAME:0];

    logic       out_free;
    logic       accept;
    logic       load;
    result_t    res;
    logic       start_replay;
    logic [2:0] name_len;
    logic [7:0] ent_char;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_enable_reg <= DECODE_ENABLE_RST;
            terminator_reg    <= TERMINATOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECODE_ENABLE: decode_enable_reg <= cfg_data[0];
                CFG_TERMINATOR:    terminator_reg    <= cfg_data;
                default:           terminator_reg    <= terminator_reg;
            endcase
        end
    end

    // Cell chain: byte enters the first empty cell, replay shifts toward cell 0
    assign full_ext[MAX_NAME]  = 1'b0;
    assign cell_data[MAX_NAME] = 8'h00;
    assign full_prev = {full_ext[MAX_NAME-2:0], 1'b1};

    for (genvar i = 0; i < MAX_NAME; i++)
    begin : g_cell
        xed_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_byte   (in_byte),
            .prev_full (full_prev[i]),
            .next_full (full_ext[i+1]),
            .next_data (cell_data[i+1]),
            .data      (cell_data[i]),
            .full      (full_ext[i])
        );
    end

    // Name length when it can match a predefined entity
    always_comb
    begin
        name_len = 3'd0;
        if (full_ext[1] && !full_ext[2])
            name_len = 3'd2;
        else if (full_ext[2] && !full_ext[3])
            name_len = 3'd3;
        else if (full_ext[3] && !full_ext[4])
            name_len = 3'd4;
    end

    assign ent_char = entity_char(cell_data[0], cell_data[1], cell_data[2], cell_data[3],
                                  name_len);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_replay)
                    state_next = S_NAME;
            end
            S_NAME:
            begin
                if (out_free && !full_ext[1])
                    state_next = S_SEMI;
            end
            S_SEMI:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the controller: result word, chain control, reference flag
    always_comb
    begin
        load         = 1'b0;
        res          = '0;
        ctrl         = '0;
        in_ref_next  = in_ref_reg;
        eot_next     = eot_reg;
        start_replay = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    res  = '{out_byte: 8'h00, byte_valid: 1'b0, run_end: 1'b1,
                             status: ST_OK, last_of_step: 1'b1};
                    if (!in_ref_reg)
                    begin
                        if (in_byte == terminator_reg)
                        begin
                            // run closed, result already set
                        end
                        else if (decode_enable_reg && in_byte == CH_AMP)
                        begin
                            ctrl.clear  = 1'b1;
                            in_ref_next = !end_of_text;
                            load        = end_of_text;
                            res.status  = ST_UNTERM;
                        end
                        else
                        begin
                            res.out_byte   = in_byte;
                            res.byte_valid = 1'b1;
                            res.run_end    = end_of_text;
                        end
                    end
                    else if (in_byte == CH_SEMI)
                    begin
                        in_ref_next = 1'b0;
                        if (!full_ext[0])
                        begin
                            ctrl.clear = 1'b1;
                            res.status = ST_EMPTY;
                        end
                        else if (ent_char != 8'h00)
                        begin
                            ctrl.clear     = 1'b1;
                            res.out_byte   = ent_char;
                            res.byte_valid = 1'b1;
                            res.run_end    = end_of_text;
                        end
                        else
                        begin
                            // unknown name: '&' now, then replay the chain
                            start_replay     = 1'b1;
                            eot_next         = end_of_text;
                            res.out_byte     = CH_AMP;
                            res.byte_valid   = 1'b1;
                            res.run_end      = 1'b0;
                            res.last_of_step = 1'b0;
                        end
                    end
                    else if (full_ext[MAX_NAME-1])
                    begin
                        ctrl.clear  = 1'b1;
                        in_ref_next = 1'b0;
                        res.status  = ST_TOO_LONG;
                    end
                    else
                    begin
                        ctrl.append = 1'b1;
                        ctrl.clear  = end_of_text;
                        in_ref_next = !end_of_text;
                        load        = end_of_text;
                        res.status  = ST_UNTERM;
                    end
                end
            end
            S_NAME:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    ctrl.shift     = 1'b1;
                    res.out_byte   = cell_data[0];
                    res.byte_valid = 1'b1;
                end
            end
            S_SEMI:
            begin
                if (out_free)
                begin
                    load             = 1'b1;
                    res.out_byte     = CH_SEMI;
                    res.byte_valid   = 1'b1;
                    res.run_end      = eot_reg;
                    res.last_of_step = 1'b1;
                end
            end
            default:
            begin
                ctrl.clear = 1'b1;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            res_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ref_reg    <= 1'b0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ref_reg    <= in_ref_next;
            eot_reg       <= eot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = res_reg.out_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign run_end      = res_reg.run_end;
    assign status       = res_reg.status;
    assign last_of_step = res_reg.last_of_step;

`ifndef NO_ASSERTIONS
    // Replay never starts or runs on an empty chain
    a_name_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NAME |-> full_ext[0])
        else $error("replay with empty name chain");

    // Chain is drained before the closing ';'
    a_semi_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEMI |-> !full_ext[0])
        else $error("name chain not drained before ';'");

    // No open reference during a replay burst
    a_no_ref_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ref_reg)
        else $error("reference open during replay");

    // Filled cells form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((full_ext >> 1) & ~full_ext) == '0)
        else $error("gap in name chain");
`endif

endmodule
